/* design/tpt_pkg.sv */
package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_W      = 8;
  localparam int FRAME_W     = 8;
  localparam int MAX_FRAMES  = 256;
  localparam int CNT_W       = 9;
  localparam int OFFSET_W    = 8;
  localparam int ADDR_W      = 16;
  localparam int CFG_DATA_W  = 9;

  localparam logic CFG_POLICY      = 1'b0;
  localparam logic CFG_FRAME_COUNT = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;

  // update request from the sequencer to the tlb
  typedef struct packed {
    logic   inval_en;
    frame_t inval_frame;
    logic   fill_en;
    page_t  fill_tag;
    frame_t fill_frame;
  } tlb_ctrl_t;

endpackage

/* design/tpt_tlb.sv */
module tpt_tlb (
  input  logic                clk,
  input  logic                rst_n,
  input  tpt_pkg::page_t      lookup_page,
  output logic                lookup_hit,
  output tpt_pkg::frame_t     lookup_frame,
  input  tpt_pkg::tlb_ctrl_t  ctrl
);

  tpt_pkg::page_t  tags_r   [tpt_pkg::TLB_ENTRIES];
  tpt_pkg::frame_t frames_r [tpt_pkg::TLB_ENTRIES];
  logic [tpt_pkg::TLB_ENTRIES-1:0] valid_r;
  logic [tpt_pkg::TLB_IDX_W-1:0]   fill_ptr_r;

  // lowest matching entry wins
  always_comb begin
    lookup_hit   = 1'b0;
    lookup_frame = '0;
    for (int i = tpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && tags_r[i] == lookup_page) begin
        lookup_hit   = 1'b1;
        lookup_frame = frames_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_ptr_r <= '0;
    end else begin
      if (ctrl.inval_en) begin
        for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++) begin
          if (valid_r[i] && frames_r[i] == ctrl.inval_frame) valid_r[i] <= 1'b0;
        end
      end
      if (ctrl.fill_en) begin
        valid_r[fill_ptr_r] <= 1'b1;
        fill_ptr_r          <= fill_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fill_en) begin
      tags_r[fill_ptr_r]   <= ctrl.fill_tag;
      frames_r[fill_ptr_r] <= ctrl.fill_frame;
    end
  end

endmodule

/* design/tlb_page_table_translator_core.sv */
// address translator: 16-entry tlb in front of a demand-paged page table
//
// input channel: in_valid / in_stall with in_logical_address (page in 15..8,
// offset in 7..0). result channel: out_valid / out_stall with the physical
// address, frame, tlb hit, page fault and eviction flags, one result per request
// config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 selects the
// replacement policy (0 fifo, 1 lru), 1 the number of usable frames
// a request steps through look, dec and route to fin; an lru reordering adds
// app_t after dec, a fault adds app_f after route, with vget before it when a
// page is evicted; one request in flight at a time and the next one is
// taken the cycle after the result is posted
// the cost is set by the linked list of resident pages (next/prev memories),
// whose pointers are updated in dec, app_t and app_f
// reset: tlb and page table empty, no frames used, policy fifo, 256 frames
// no clearing pass is needed: memories are only read behind resident bits
// when the receiver stalls the result sits in the output register; the next
// request still runs and then waits in its last state until the register frees
module tlb_page_table_translator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tpt_pkg::ADDR_W-1:0]       in_logical_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tpt_pkg::ADDR_W-1:0]       out_physical_address,
  output logic [tpt_pkg::FRAME_W-1:0]      out_frame_number,
  output logic                             out_tlb_hit,
  output logic                             out_page_fault,
  output logic                             out_evicted,
  output logic [tpt_pkg::PAGE_W-1:0]       out_evicted_page,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [tpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DEC, S_APP_T, S_ROUTE, S_VGET, S_APP_F, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic                           policy_r;
  logic [tpt_pkg::CNT_W-1:0]      fcount_r;
  logic [tpt_pkg::CNT_W-1:0]      usable;

  // request context
  tpt_pkg::page_t                 page_r;
  logic [tpt_pkg::OFFSET_W-1:0]   offset_r;
  tpt_pkg::frame_t                frame_r;
  tpt_pkg::frame_t                tlbf_r;
  logic                           hit_r;
  logic                           resident_r;
  logic                           fault_r;
  logic                           evict_r;
  tpt_pkg::page_t                 evpage_r;

  // page table and resident list
  logic [tpt_pkg::PAGE_COUNT-1:0] res_r;
  logic [tpt_pkg::CNT_W-1:0]      frames_used_r;
  logic [tpt_pkg::CNT_W-1:0]      len_r;
  tpt_pkg::page_t                 head_r;
  tpt_pkg::page_t                 tail_r;

  tpt_pkg::frame_t map_mem  [tpt_pkg::PAGE_COUNT];
  tpt_pkg::page_t  next_mem [tpt_pkg::PAGE_COUNT];
  tpt_pkg::page_t  prev_mem [tpt_pkg::PAGE_COUNT];
  tpt_pkg::frame_t map_rd_r;
  tpt_pkg::page_t  next_rd_r;
  tpt_pkg::page_t  prev_rd_r;

  logic            rd_en;
  tpt_pkg::page_t  rd_addr;
  logic            nxt_we, prv_we, map_we;
  tpt_pkg::page_t  nxt_wa, nxt_wd, prv_wa, prv_wd;

  // tlb
  logic               tlb_hit;
  tpt_pkg::frame_t    tlb_frame;
  tpt_pkg::tlb_ctrl_t tlb_ctrl;

  logic out_free;
  logic touch_move;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // zero frames behaves as one, above the maximum as the maximum
  always_comb begin
    if (fcount_r == '0) usable = tpt_pkg::CNT_W'(1);
    else if (fcount_r > tpt_pkg::CNT_W'(tpt_pkg::MAX_FRAMES))
      usable = tpt_pkg::CNT_W'(tpt_pkg::MAX_FRAMES);
    else usable = fcount_r;
  end

  // lru hit on a page that is not already most recent: unlink and re-append
  assign touch_move = (policy_r == tpt_pkg::POLICY_LRU) && resident_r && (page_r != tail_r);

  tpt_tlb u_tlb (
    .clk          (clk),
    .rst_n        (rst_n),
    .lookup_page  (page_r),
    .lookup_hit   (tlb_hit),
    .lookup_frame (tlb_frame),
    .ctrl         (tlb_ctrl)
  );

  always_comb begin
    tlb_ctrl             = '0;
    tlb_ctrl.inval_frame = frame_r;
    tlb_ctrl.fill_tag    = page_r;
    tlb_ctrl.fill_frame  = frame_r;
    // stale translations of the reused frame go away
    tlb_ctrl.inval_en    = (state_r == S_APP_F);
    // any tlb miss refills round-robin
    tlb_ctrl.fill_en     = (state_r == S_FIN) && out_free && !hit_r;
  end

  // list and page table memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = page_r;
    nxt_we  = 1'b0;
    nxt_wa  = tail_r;
    nxt_wd  = page_r;
    prv_we  = 1'b0;
    prv_wa  = page_r;
    prv_wd  = tail_r;
    map_we  = 1'b0;
    unique case (state_r)
      S_LOOK: begin
        rd_en = 1'b1;
      end
      S_DEC: begin
        if (touch_move) begin
          // bridge the neighbors of the touched page
          nxt_we = (page_r != head_r);
          nxt_wa = prev_rd_r;
          nxt_wd = next_rd_r;
          prv_we = 1'b1;
          prv_wa = next_rd_r;
          prv_wd = prev_rd_r;
        end
      end
      S_APP_T: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      S_ROUTE: begin
        // victim is the list head, fetch its frame and successor
        rd_en   = !resident_r && !(frames_used_r < usable) && (len_r != '0);
        rd_addr = head_r;
      end
      S_APP_F: begin
        nxt_we = (len_r != '0);
        prv_we = (len_r != '0);
        map_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      map_rd_r  <= map_mem[rd_addr];
      next_rd_r <= next_mem[rd_addr];
      prev_rd_r <= prev_mem[rd_addr];
    end
    if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prev_mem[prv_wa] <= prv_wd;
    if (map_we) map_mem[page_r] <= frame_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      policy_r      <= tpt_pkg::POLICY_FIFO;
      fcount_r      <= tpt_pkg::CNT_W'(tpt_pkg::MAX_FRAMES);
      res_r         <= '0;
      frames_used_r <= '0;
      len_r         <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      out_valid     <= 1'b0;
      hit_r         <= 1'b0;
      fault_r       <= 1'b0;
      evict_r       <= 1'b0;
      evpage_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tpt_pkg::CFG_POLICY:      policy_r <= cfg_data[0];
          tpt_pkg::CFG_FRAME_COUNT: fcount_r <= cfg_data;
          default: begin
          end
        endcase
      end
      // a result taken while a new one is posted is handled in S_FIN
      if (out_valid && !out_stall && state_r != S_FIN) out_valid <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            page_r   <= in_logical_address[tpt_pkg::ADDR_W-1:tpt_pkg::OFFSET_W];
            offset_r <= in_logical_address[tpt_pkg::OFFSET_W-1:0];
            fault_r  <= 1'b0;
            evict_r  <= 1'b0;
            evpage_r <= '0;
            state_r  <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_r      <= tlb_hit;
          tlbf_r     <= tlb_frame;
          resident_r <= res_r[page_r];
          state_r    <= S_DEC;
        end
        S_DEC: begin
          frame_r <= hit_r ? tlbf_r : map_rd_r;
          if (touch_move) begin
            if (page_r == head_r) head_r <= next_rd_r;
            state_r <= S_APP_T;
          end else begin
            state_r <= S_ROUTE;
          end
        end
        S_APP_T: begin
          tail_r  <= page_r;
          state_r <= S_ROUTE;
        end
        S_ROUTE: begin
          if (resident_r) begin
            state_r <= S_FIN;
          end else begin
            fault_r <= 1'b1;
            if (frames_used_r < usable) begin
              frame_r       <= frames_used_r[tpt_pkg::FRAME_W-1:0];
              frames_used_r <= frames_used_r + 1'b1;
              state_r       <= S_APP_F;
            end else if (len_r != '0) begin
              state_r <= S_VGET;
            end else begin
              frame_r <= '0;
              state_r <= S_APP_F;
            end
          end
        end
        S_VGET: begin
          frame_r        <= map_rd_r;
          evict_r        <= 1'b1;
          evpage_r       <= head_r;
          res_r[head_r]  <= 1'b0;
          head_r         <= next_rd_r;
          len_r          <= len_r - 1'b1;
          state_r        <= S_APP_F;
        end
        S_APP_F: begin
          if (len_r == '0) head_r <= page_r;
          tail_r        <= page_r;
          len_r         <= len_r + 1'b1;
          res_r[page_r] <= 1'b1;
          state_r       <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_physical_address <= {frame_r, offset_r};
            out_frame_number     <= frame_r;
            out_tlb_hit          <= hit_r;
            out_page_fault       <= fault_r;
            out_evicted          <= evict_r;
            out_evicted_page     <= evpage_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
